/* design/fhwm_pkg.sv */
// Shared types and constants for the founder haplotype window matcher.
`default_nettype none
package fhwm_pkg;

	// parameter defaults
	localparam int DEF_MAX_SNPS     = 4096;
	localparam int DEF_MAX_FOUNDERS = 16;
	localparam int DEF_MAX_WINDOW   = 16;

	// configuration register indexes
	localparam logic [1:0] REG_SNP_COUNT     = 2'd0;
	localparam logic [1:0] REG_FOUNDER_COUNT = 2'd1;
	localparam logic [1:0] REG_WINDOW_LIMIT  = 2'd2;

	// configuration reset values
	localparam logic [12:0] RST_SNP_COUNT     = 13'd4096;
	localparam logic [4:0]  RST_FOUNDER_COUNT = 5'd8;
	localparam logic [4:0]  RST_WINDOW_LIMIT  = 5'd16;

	// opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_GENO = 1'b1;

	// request queue and genotype ring
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PW    = 2;
	localparam int HIST_DEPTH  = 32;
	localparam int HIST_AW     = 5;

	// calls produced by one request at most
	localparam logic [4:0] MAX_CALLS = 5'd16;

	// call codes
	localparam logic [5:0] CALL_MISSING    = 6'h3F;
	localparam logic [5:0] CALL_UNRESOLVED = 6'h00;

	// classified request
	typedef struct packed {
		logic        is_load;
		logic        load_ok;
		logic [11:0] index;
		logic [15:0] bits;
		logic [1:0]  genotype;
	} item_t;

endpackage
`default_nettype wire

/* design/fhwm_front.sv */
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none
module fhwm_front #(
	parameter int MAX_SNPS = fhwm_pkg::DEF_MAX_SNPS
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  wire                  opcode,
	input  wire  [11:0]          snp_index,
	input  wire  [15:0]          founder_bits,
	input  wire  [1:0]           genotype,
	output fhwm_pkg::item_t      item,
	output logic                 item_valid,
	input  wire                  pop
);

	fhwm_pkg::item_t                  queue_q [fhwm_pkg::QUEUE_DEPTH];
	logic [fhwm_pkg::QUEUE_PW:0]      wptr_q, rptr_q;
	logic                             full, empty, push;
	fhwm_pkg::item_t                  cls;

	assign full  = (wptr_q[fhwm_pkg::QUEUE_PW] != rptr_q[fhwm_pkg::QUEUE_PW]) &&
	               (wptr_q[fhwm_pkg::QUEUE_PW-1:0] == rptr_q[fhwm_pkg::QUEUE_PW-1:0]);
	assign empty = (wptr_q == rptr_q);
	assign busy  = full;
	assign push  = start && !full;

	// classify the request
	always_comb begin
		cls.is_load  = (opcode == fhwm_pkg::OP_LOAD);
		cls.load_ok  = (32'(snp_index) < 32'(MAX_SNPS));
		cls.index    = snp_index;
		cls.bits     = founder_bits;
		cls.genotype = genotype;
	end

	// hold queued requests
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wptr_q[fhwm_pkg::QUEUE_PW-1:0]] <= cls;
		end
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop && !empty) rptr_q <= rptr_q + 1'b1;
		end
	end

	assign item       = queue_q[rptr_q[fhwm_pkg::QUEUE_PW-1:0]];
	assign item_valid = !empty;

endmodule
`default_nettype wire

/* design/fhwm_back.sv */
// Back end: founder matrix, genotype ring and the per-SNP window search.
`default_nettype none
module fhwm_back #(
	parameter int MAX_SNPS     = fhwm_pkg::DEF_MAX_SNPS,
	parameter int MAX_FOUNDERS = fhwm_pkg::DEF_MAX_FOUNDERS,
	localparam int AW  = $clog2(MAX_SNPS),
	localparam int NW  = $clog2(MAX_SNPS + 1),
	localparam int FCW = $clog2(MAX_FOUNDERS + 1),
	localparam int FW  = $clog2(MAX_FOUNDERS)
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  fhwm_pkg::item_t      item,
	input  wire                  item_valid,
	output logic                 pop,
	input  wire                  restart,
	input  wire  [NW-1:0]        n,
	input  wire  [FCW-1:0]       nf,
	input  wire  [4:0]           w,
	output logic                 strobe,
	output logic [11:0]          snp_position,
	output logic signed [5:0]    hap_call,
	output logic                 last_of_run,
	output logic                 individual_done
);

	typedef enum logic [2:0] {S_IDLE, S_CHECK, S_READ, S_EVAL, S_DONE} state_t;

	state_t                  state_q;
	logic [MAX_FOUNDERS-1:0] mat [MAX_SNPS];
	logic [1:0]              hist [fhwm_pkg::HIST_DEPTH];
	logic [MAX_FOUNDERS-1:0] rr_q, rl_q;
	logic [1:0]              hr_q, hl_q;

	logic [AW-1:0]  sp_q, p_q, left_q, pend_pos_q;
	logic [NW-1:0]  ncp_q;
	logic [4:0]     count_q, off_q;
	logic [5:0]     pend_call_q, call_now_q;
	logic           pend_valid_q, pend_done_q;
	logic [MAX_FOUNDERS-1:0] eq_q [MAX_FOUNDERS];
	logic [MAX_FOUNDERS-1:0] m_q;

	logic [MAX_FOUNDERS-1:0] load_bits, fmask, uniq, m_new;
	logic [MAX_FOUNDERS-1:0] eq_new [MAX_FOUNDERS];
	logic [AW-1:0]  addr_r, addr_l, p_now;
	logic [NW:0]    half, rem, mrg, ready;
	logic           can_call, in_window, miss, hit, all_uniq, wrap;
	logic [FW-1:0]  sel;
	logic [5:0]     new_call;

	// founder column bits, dropping those above the founder limit
	always_comb begin
		for (int f = 0; f < MAX_FOUNDERS; f++) begin
			load_bits[f] = (f < 16) ? item.bits[f % 16] : 1'b0;
			fmask[f]     = (32'(f) < 32'(nf));
		end
	end

	assign pop  = (state_q == S_IDLE) && item_valid;
	assign wrap = ((NW+1)'(sp_q) >= (NW+1)'(n));
	assign p_now = wrap ? '0 : sp_q;

	// window readiness of the next call
	always_comb begin
		half = (w == 5'd0) ? '0 : (NW+1)'(w - 5'd1);
		rem  = (NW+1)'(n) - (NW+1)'(1) - (NW+1)'(ncp_q);
		mrg  = half;
		if ((NW+1)'(ncp_q) < mrg) mrg = (NW+1)'(ncp_q);
		if (rem < mrg) mrg = rem;
		ready = (NW+1)'(ncp_q) + mrg;
		can_call = (ncp_q < n) && (ready <= (NW+1)'(p_q)) && (count_q < fhwm_pkg::MAX_CALLS);
		in_window = ({1'b0, off_q} < {1'b0, w}) &&
		            ((NW+1)'(left_q) + (NW+1)'(off_q) < (NW+1)'(n)) &&
		            ({1'b0, left_q} >= (AW+1)'(off_q));
	end

	assign addr_r = AW'((AW+1)'(left_q) + (AW+1)'(off_q));
	assign addr_l = AW'((AW+1)'(left_q) - (AW+1)'(off_q));

	// store founder columns and genotypes, registered reads
	always_ff @(posedge clk) begin
		if (pop && item.is_load && item.load_ok) mat[AW'(item.index)] <= load_bits;
		if (pop && !item.is_load) hist[fhwm_pkg::HIST_AW'(p_now)] <= item.genotype;
		rr_q <= mat[addr_r];
		rl_q <= mat[addr_l];
		hr_q <= hist[fhwm_pkg::HIST_AW'(addr_r)];
		hl_q <= hist[fhwm_pkg::HIST_AW'(addr_l)];
	end

	// evaluate one offset: equality classes, individual match, uniqueness
	always_comb begin
		miss = hr_q[1] || ((off_q != 5'd0) && hl_q[1]);
		for (int f = 0; f < MAX_FOUNDERS; f++) begin
			for (int g = 0; g < MAX_FOUNDERS; g++) begin
				eq_new[f][g] = eq_q[f][g] && (rr_q[f] == rr_q[g]) &&
				               ((off_q == 5'd0) || (rl_q[f] == rl_q[g]));
			end
			m_new[f] = m_q[f] && (rr_q[f] == hr_q[0]) &&
			           ((off_q == 5'd0) || (rl_q[f] == hl_q[0]));
		end
		hit = 1'b0;
		sel = '0;
		for (int f = 0; f < MAX_FOUNDERS; f++) begin
			uniq[f] = fmask[f];
			for (int g = 0; g < MAX_FOUNDERS; g++) begin
				if (g != f && fmask[g] && eq_new[f][g]) uniq[f] = 1'b0;
			end
			if (uniq[f] && m_new[f]) begin
				hit = 1'b1;
				sel = FW'(f);
			end
		end
		all_uniq = &(uniq | ~fmask);
		new_call = 6'((FW+1)'(sel) + (FW+1)'(1));
	end

	// sequence the calls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			sp_q            <= '0;
			ncp_q           <= '0;
			p_q             <= '0;
			count_q         <= '0;
			left_q          <= '0;
			off_q           <= '0;
			pend_valid_q    <= 1'b0;
			pend_pos_q      <= '0;
			pend_call_q     <= '0;
			pend_done_q     <= 1'b0;
			call_now_q      <= '0;
			m_q             <= '0;
			for (int f = 0; f < MAX_FOUNDERS; f++) eq_q[f] <= '0;
			strobe          <= 1'b0;
			snp_position    <= '0;
			hap_call        <= '0;
			last_of_run     <= 1'b0;
			individual_done <= 1'b0;
		end else begin
			strobe <= 1'b0;
			if (restart) begin
				sp_q  <= '0;
				ncp_q <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop && !item.is_load) begin
						p_q     <= p_now;
						count_q <= '0;
						if (wrap) ncp_q <= '0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (can_call) begin
						left_q     <= AW'(ncp_q);
						off_q      <= '0;
						call_now_q <= fhwm_pkg::CALL_UNRESOLVED;
						for (int f = 0; f < MAX_FOUNDERS; f++) eq_q[f] <= '1;
						m_q     <= '1;
						state_q <= S_READ;
					end else begin
						// flush the held call as the last of this request
						if (pend_valid_q) begin
							strobe          <= 1'b1;
							snp_position    <= 12'(pend_pos_q);
							hap_call        <= pend_call_q;
							last_of_run     <= 1'b1;
							individual_done <= pend_done_q;
							pend_valid_q    <= 1'b0;
						end
						if ((NW+1)'(p_q) + (NW+1)'(1) >= (NW+1)'(n)) begin
							sp_q  <= '0;
							ncp_q <= '0;
						end else begin
							sp_q <= AW'((AW+1)'(p_q) + (AW+1)'(1));
						end
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					if (in_window) begin
						state_q <= S_EVAL;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_EVAL: begin
					for (int f = 0; f < MAX_FOUNDERS; f++) eq_q[f] <= eq_new[f];
					m_q <= m_new;
					if (miss) begin
						call_now_q <= fhwm_pkg::CALL_MISSING;
						state_q    <= S_DONE;
					end else if (hit) begin
						call_now_q <= new_call;
						state_q    <= S_DONE;
					end else if (all_uniq) begin
						state_q <= S_DONE;
					end else begin
						off_q   <= off_q + 5'd1;
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					// emit the previous held call, hold this one
					if (pend_valid_q) begin
						strobe          <= 1'b1;
						snp_position    <= 12'(pend_pos_q);
						hap_call        <= pend_call_q;
						last_of_run     <= 1'b0;
						individual_done <= pend_done_q;
					end
					pend_valid_q <= 1'b1;
					pend_pos_q   <= left_q;
					pend_done_q  <= ((NW+1)'(left_q) + (NW+1)'(1) == (NW+1)'(n));
					pend_call_q  <= call_now_q;
					count_q <= count_q + 5'd1;
					ncp_q   <= NW'((NW+1)'(left_q) + (NW+1)'(1));
					state_q <= S_CHECK;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* design/founder_haplotype_window_match.sv */
// A founder load is written into the founder matrix when it leaves the queue; a
// genotype request is checked, then each call reads and evaluates each window
// offset searched (one founder-matrix read pair per offset), up to 16 offsets.
// The back end takes one request at a time and makes at most 16 calls per
// request; busy rises while the 4-entry queue is full.
// The receiver cannot stall; each call is strobed for one cycle, one call behind
// the search. Reset clears all control state; the founder matrix is undefined
// until loaded.
`default_nettype none
module founder_haplotype_window_match #(
	parameter int MAX_SNPS     = fhwm_pkg::DEF_MAX_SNPS,
	parameter int MAX_FOUNDERS = fhwm_pkg::DEF_MAX_FOUNDERS,
	parameter int MAX_WINDOW   = fhwm_pkg::DEF_MAX_WINDOW
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire               opcode,
	input  wire  [11:0]       snp_index,
	input  wire  [15:0]       founder_bits,
	input  wire  [1:0]        genotype,
	input  wire               write_enable,
	input  wire  [1:0]        reg_index,
	input  wire  [12:0]       write_data,
	output logic              strobe,
	output logic [11:0]       snp_position,
	output logic signed [5:0] hap_call,
	output logic              last_of_run,
	output logic              individual_done
);

	localparam int NW  = $clog2(MAX_SNPS + 1);
	localparam int FCW = $clog2(MAX_FOUNDERS + 1);

	logic [12:0]     snp_count_q;
	logic [4:0]      founder_count_q, window_limit_q;
	logic [NW-1:0]   n;
	logic [FCW-1:0]  nf;
	logic [4:0]      w;
	logic            restart, item_valid, pop;
	fhwm_pkg::item_t item;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snp_count_q     <= fhwm_pkg::RST_SNP_COUNT;
			founder_count_q <= fhwm_pkg::RST_FOUNDER_COUNT;
			window_limit_q  <= fhwm_pkg::RST_WINDOW_LIMIT;
		end else if (write_enable) begin
			case (reg_index)
				fhwm_pkg::REG_SNP_COUNT:     snp_count_q     <= write_data;
				fhwm_pkg::REG_FOUNDER_COUNT: founder_count_q <= write_data[4:0];
				fhwm_pkg::REG_WINDOW_LIMIT:  window_limit_q  <= write_data[4:0];
				default: ;
			endcase
		end
	end

	assign restart = write_enable && (reg_index inside {fhwm_pkg::REG_SNP_COUNT,
	                 fhwm_pkg::REG_FOUNDER_COUNT, fhwm_pkg::REG_WINDOW_LIMIT});

	// saturate configuration to the built limits
	always_comb begin
		if (snp_count_q == 13'd0) n = NW'(1);
		else if (32'(snp_count_q) > 32'(MAX_SNPS)) n = NW'(MAX_SNPS);
		else n = NW'(snp_count_q);
		if (32'(founder_count_q) > 32'(MAX_FOUNDERS)) nf = FCW'(MAX_FOUNDERS);
		else nf = FCW'(founder_count_q);
		if (32'(window_limit_q) > 32'(MAX_WINDOW)) w = 5'(MAX_WINDOW);
		else w = window_limit_q;
	end

	fhwm_front #(
		.MAX_SNPS(MAX_SNPS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.snp_index    (snp_index),
		.founder_bits (founder_bits),
		.genotype     (genotype),
		.item         (item),
		.item_valid   (item_valid),
		.pop          (pop)
	);

	fhwm_back #(
		.MAX_SNPS     (MAX_SNPS),
		.MAX_FOUNDERS (MAX_FOUNDERS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.item            (item),
		.item_valid      (item_valid),
		.pop             (pop),
		.restart         (restart),
		.n               (n),
		.nf              (nf),
		.w               (w),
		.strobe          (strobe),
		.snp_position    (snp_position),
		.hap_call        (hap_call),
		.last_of_run     (last_of_run),
		.individual_done (individual_done)
	);

endmodule
`default_nettype wire
